// ===== design/tcc_pkg.sv =====
package tcc_pkg;

  localparam int unsigned MaxColumns = 128;
  localparam int unsigned MaxRows    = 64;
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned ColW = $clog2(MaxColumns);
  localparam int unsigned RowW = $clog2(MaxRows);

  typedef enum logic [2:0] {
    FUNC_CHAR   = 3'd0,
    FUNC_TICK   = 3'd1,
    FUNC_SETPOS = 3'd2,
    FUNC_ENABLE = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    KIND_GLYPH     = 2'd0,
    KIND_UNDERLINE = 2'd1,
    KIND_SCROLL    = 2'd2,
    KIND_CLEAR     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_TEXT_COLUMNS = 3'd0,
    REG_TEXT_ROWS    = 3'd1,
    REG_FORE_INDEX   = 3'd2,
    REG_BACK_INDEX   = 3'd3,
    REG_BLINK_PERIOD = 3'd4
  } reg_e;

  localparam logic [7:0] CharNewline   = 8'd10;
  localparam logic [7:0] CharBackspace = 8'd8;
  localparam logic [7:0] CharSpace     = 8'd32;

  localparam logic [7:0] ResetColumns = 8'd80;
  localparam logic [6:0] ResetRows    = 7'd25;
  localparam logic [3:0] ResetFore    = 4'd15;
  localparam logic [3:0] ResetBack    = 4'd0;
  localparam logic [7:0] ResetBlink   = 8'd50;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] byte_in;
    logic [6:0] new_col;
    logic [5:0] new_row;
    logic       enable_on;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  cell_col;
    logic [5:0]  cell_row;
    logic [7:0]  glyph_code;
    logic [23:0] fore_rgb;
    logic [23:0] back_rgb;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] text_columns;
    logic [6:0] text_rows;
    logic [3:0] fore_index;
    logic [3:0] back_index;
    logic [7:0] blink_period;
  } cfg_t;

  // One classified event: up to four draw steps, issued in field order.
  typedef struct packed {
    logic       ul_en;
    logic       ul_show;
    logic [6:0] ul_col;
    logic [5:0] ul_row;
    logic       gl_en;
    logic [6:0] gl_col;
    logic [5:0] gl_row;
    logic [7:0] gl_code;
    logic       sc_en;
    logic       cl_en;
  } cmd_t;

  function automatic logic [23:0] vga_rgb(input logic [3:0] idx);
    logic [23:0] c;
    unique case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'h0000AA;
      4'd2:    c = 24'h00AA00;
      4'd3:    c = 24'h00AAAA;
      4'd4:    c = 24'hAA0000;
      4'd5:    c = 24'hAA00AA;
      4'd6:    c = 24'hAA5500;
      4'd7:    c = 24'hAAAAAA;
      4'd8:    c = 24'h555555;
      4'd9:    c = 24'h5555FF;
      4'd10:   c = 24'h55FF55;
      4'd11:   c = 24'h55FFFF;
      4'd12:   c = 24'hFF5555;
      4'd13:   c = 24'hFF55FF;
      4'd14:   c = 24'hFFFF55;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

endpackage

// ===== design/tcc_front.sv =====
module tcc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tcc_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tcc_pkg::in_item_t in_data_i,
  output logic            push_o,
  output tcc_pkg::cmd_t   cmd_o,
  input  logic            full_i
);
  import tcc_pkg::*;

  logic [6:0] col_q, col_d;
  logic [5:0] row_q, row_d;
  logic       on_q, on_d;
  logic       shown_q, shown_d;
  logic [7:0] blink_q, blink_d;

  logic [7:0] cols;
  logic [6:0] rows;
  logic       accept;
  logic       emit;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && emit;

  always_comb begin
    if (cfg_i.text_columns == 8'd0) begin
      cols = 8'd1;
    end else if (cfg_i.text_columns > 8'(MaxColumns)) begin
      cols = 8'(MaxColumns);
    end else begin
      cols = cfg_i.text_columns;
    end
    if (cfg_i.text_rows == 7'd0) begin
      rows = 7'd1;
    end else if (cfg_i.text_rows > 7'(MaxRows)) begin
      rows = 7'(MaxRows);
    end else begin
      rows = cfg_i.text_rows;
    end
  end

  always_comb begin
    logic [6:0] row_inc;
    logic [7:0] col_inc;
    logic       wrap;
    logic [8:0] blink_inc;
    row_inc = {1'b0, row_q} + 7'd1;
    col_inc = {1'b0, col_q} + 8'd1;
    wrap    = 1'b0;
    blink_inc = {1'b0, blink_q} + 9'd1;

    col_d   = col_q;
    row_d   = row_q;
    on_d    = on_q;
    shown_d = shown_q;
    blink_d = blink_q;
    cmd_o   = '0;
    cmd_o.ul_col = col_q;
    cmd_o.ul_row = row_q;
    cmd_o.gl_col = col_q;
    cmd_o.gl_row = row_q;
    cmd_o.gl_code = in_data_i.byte_in;

    unique case (in_data_i.func)
      FUNC_CHAR: begin
        cmd_o.ul_en = on_q && shown_q;
        if (in_data_i.byte_in == CharNewline) begin
          col_d = '0;
          wrap  = 1'b1;
        end else if (in_data_i.byte_in == CharBackspace) begin
          cmd_o.gl_en   = 1'b1;
          cmd_o.gl_code = CharSpace;
          if (col_q != '0) begin
            col_d = col_q - 7'd1;
          end else if (row_q != '0) begin
            row_d = row_q - 6'd1;
            col_d = 7'(cols - 8'd1);
          end
          cmd_o.gl_col = col_d;
          cmd_o.gl_row = row_d;
        end else begin
          cmd_o.gl_en = 1'b1;
          if (col_inc >= cols) begin
            col_d = '0;
            wrap  = 1'b1;
          end else begin
            col_d = col_inc[6:0];
          end
        end
        // Moving to the next row scrolls once the bottom row is passed.
        if (wrap) begin
          if (row_inc >= rows) begin
            cmd_o.sc_en = 1'b1;
            row_d = 6'(rows - 7'd1);
          end else begin
            row_d = row_inc[5:0];
          end
        end
      end
      FUNC_TICK: begin
        if (on_q) begin
          if (blink_inc < {1'b0, cfg_i.blink_period}) begin
            blink_d = blink_inc[7:0];
          end else begin
            blink_d       = '0;
            shown_d       = !shown_q;
            cmd_o.ul_en   = 1'b1;
            cmd_o.ul_show = !shown_q;
          end
        end
      end
      FUNC_SETPOS: begin
        cmd_o.ul_en = on_q && shown_q;
        col_d = in_data_i.new_col;
        row_d = in_data_i.new_row;
      end
      FUNC_ENABLE: begin
        on_d = in_data_i.enable_on;
        if (!in_data_i.enable_on) begin
          cmd_o.ul_en = 1'b1;
          shown_d     = 1'b0;
          blink_d     = '0;
        end
      end
      FUNC_CLEAR: begin
        col_d       = '0;
        row_d       = '0;
        on_d        = 1'b0;
        shown_d     = 1'b0;
        blink_d     = '0;
        cmd_o.cl_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign emit = cmd_o.ul_en || cmd_o.gl_en || cmd_o.sc_en || cmd_o.cl_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      on_q    <= 1'b0;
      shown_q <= 1'b0;
      blink_q <= '0;
    end else if (accept) begin
      col_q   <= col_d;
      row_q   <= row_d;
      on_q    <= on_d;
      shown_q <= shown_d;
      blink_q <= blink_d;
    end
  end

endmodule

// ===== design/tcc_queue.sv =====
module tcc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcc_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tcc_pkg::cmd_t head_o
);
  import tcc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slots_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/tcc_back.sv =====
module tcc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcc_pkg::cfg_t      cfg_i,
  input  logic               empty_i,
  input  tcc_pkg::cmd_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcc_pkg::out_item_t out_data_o
);
  import tcc_pkg::*;

  logic [3:0] done_q, done_d;
  logic [3:0] pend;
  logic [3:0] sel;
  logic [3:0] rest;
  logic       can_load;
  logic       fire;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic [23:0] fore_rgb;
  logic [23:0] back_rgb;

  assign fore_rgb = vga_rgb(cfg_i.fore_index);
  assign back_rgb = vga_rgb(cfg_i.back_index);

  // Steps still owed by the head entry: underline, glyph, scroll, clear.
  assign pend = {head_i.cl_en, head_i.sc_en, head_i.gl_en, head_i.ul_en} & ~done_q;
  assign sel  = pend & (~pend + 4'd1);
  assign rest = pend & ~sel;

  assign can_load = !out_valid_q || out_ready_i;
  assign fire     = !empty_i && (pend != '0) && can_load;
  assign pop_o    = fire && (rest == '0);

  always_comb begin
    out_d = '0;
    out_d.last = (rest == '0);
    priority if (sel[0]) begin
      out_d.kind     = KIND_UNDERLINE;
      out_d.cell_col = head_i.ul_col;
      out_d.cell_row = head_i.ul_row;
      out_d.fore_rgb = head_i.ul_show ? fore_rgb : back_rgb;
    end else if (sel[1]) begin
      out_d.kind       = KIND_GLYPH;
      out_d.cell_col   = head_i.gl_col;
      out_d.cell_row   = head_i.gl_row;
      out_d.glyph_code = head_i.gl_code;
      out_d.fore_rgb   = fore_rgb;
      out_d.back_rgb   = back_rgb;
    end else if (sel[2]) begin
      out_d.kind     = KIND_SCROLL;
      out_d.back_rgb = back_rgb;
    end else begin
      out_d.kind     = KIND_CLEAR;
      out_d.back_rgb = back_rgb;
    end
  end

  always_comb begin
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (can_load) begin
      out_valid_d = fire;
    end
    if (fire) begin
      done_d = (rest == '0) ? '0 : (done_q | sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/text_console_cursor_engine.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_data_i   (in_item_t)
// out       output     out_valid_o / out_ready_i  out_data_o  (out_item_t)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An event is classified and the cursor state updated in the cycle it is accepted;
// its draw commands (one to three) leave the result register one per cycle while the
// result side does not stall, through the single result port. Events that draw
// nothing queue no command. A two-entry command queue lets input keep flowing
// while the result side stalls. Reset clears the cursor state and loads the
// register defaults; no clearing pass is needed.
module text_console_cursor_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcc_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import tcc_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TEXT_COLUMNS: cfg_d.text_columns = cfg_data_i;
        REG_TEXT_ROWS:    cfg_d.text_rows    = cfg_data_i[6:0];
        REG_FORE_INDEX:   cfg_d.fore_index   = cfg_data_i[3:0];
        REG_BACK_INDEX:   cfg_d.back_index   = cfg_data_i[3:0];
        REG_BLINK_PERIOD: cfg_d.blink_period = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_columns <= ResetColumns;
      cfg_q.text_rows    <= ResetRows;
      cfg_q.fore_index   <= ResetFore;
      cfg_q.back_index   <= ResetBack;
      cfg_q.blink_period <= ResetBlink;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tcc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  tcc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_cmd)
  );

  tcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/sv/text_console_cursor_checker.sv =====
`timescale 1ns / 1ps

module text_console_cursor_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  tcc_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  tcc_pkg::out_item_t out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  import tcc_pkg::*;

  // Sixteen-color text palette, index 15 first.
  localparam logic [15:0][23:0] Palette = {
    24'hFFFFFF, 24'hFFFF55, 24'hFF55FF, 24'hFF5555,
    24'h55FFFF, 24'h55FF55, 24'h5555FF, 24'h555555,
    24'hAAAAAA, 24'hAA5500, 24'hAA00AA, 24'hAA0000,
    24'h00AAAA, 24'h00AA00, 24'h0000AA, 24'h000000
  };

  logic [7:0] columns_q;
  logic [6:0] rows_q;
  logic [3:0] fore_q;
  logic [3:0] back_q;
  logic [7:0] blink_period_q;

  logic [6:0] cur_col;
  logic [5:0] cur_row;
  logic       cur_on;
  logic       cur_shown;
  logic [7:0] blink_cnt;

  out_item_t event_draws[$];
  out_item_t pending_draws[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic int unsigned grid_columns();
    if (columns_q == 0) return 1;
    if (columns_q > 128) return 128;
    return columns_q;
  endfunction

  function automatic int unsigned grid_rows();
    if (rows_q == 0) return 1;
    if (rows_q > 64) return 64;
    return rows_q;
  endfunction

  function automatic void add_draw(kind_e kind, logic [6:0] col, logic [5:0] row,
                                   logic [7:0] glyph, logic [23:0] fg, logic [23:0] bg);
    out_item_t d;
    d.kind       = kind;
    d.cell_col   = col;
    d.cell_row   = row;
    d.glyph_code = glyph;
    d.fore_rgb   = fg;
    d.back_rgb   = bg;
    d.last       = 1'b0;
    event_draws.push_back(d);
  endfunction

  // Showing uses the foreground color, erasing uses the background color.
  function automatic void draw_underline(logic show);
    add_draw(KIND_UNDERLINE, cur_col, cur_row, 8'd0,
             show ? Palette[fore_q] : Palette[back_q], 24'd0);
  endfunction

  function automatic void advance_row();
    int unsigned r;
    r = cur_row + 1;
    if (r >= grid_rows()) begin
      add_draw(KIND_SCROLL, 7'd0, 6'd0, 8'd0, 24'd0, Palette[back_q]);
      r = grid_rows() - 1;
    end
    cur_row = r[5:0];
  endfunction

  function automatic void write_char(logic [7:0] ch);
    int unsigned cols;
    cols = grid_columns();
    if (cur_on && cur_shown) draw_underline(1'b0);
    if (ch == CharNewline) begin
      cur_col = '0;
      advance_row();
      return;
    end
    if (ch == CharBackspace) begin
      if (cur_col != 0) begin
        cur_col = cur_col - 7'd1;
      end else if (cur_row != 0) begin
        cur_row = cur_row - 6'd1;
        cur_col = 7'(cols - 1);
      end
      add_draw(KIND_GLYPH, cur_col, cur_row, CharSpace, Palette[fore_q], Palette[back_q]);
      return;
    end
    add_draw(KIND_GLYPH, cur_col, cur_row, ch, Palette[fore_q], Palette[back_q]);
    if (cur_col + 1 >= cols) begin
      cur_col = '0;
      advance_row();
    end else begin
      cur_col = cur_col + 7'd1;
    end
  endfunction

  function automatic void predict_event(in_item_t ev);
    int unsigned n;
    event_draws.delete();
    case (ev.func)
      FUNC_CHAR: write_char(ev.byte_in);
      FUNC_TICK: begin
        if (cur_on) begin
          n = blink_cnt + 1;
          if (n < blink_period_q) begin
            blink_cnt = n[7:0];
          end else begin
            blink_cnt = '0;
            cur_shown = !cur_shown;
            draw_underline(cur_shown);
          end
        end
      end
      FUNC_SETPOS: begin
        if (cur_on && cur_shown) draw_underline(1'b0);
        cur_col = ev.new_col;
        cur_row = ev.new_row;
      end
      FUNC_ENABLE: begin
        cur_on = ev.enable_on;
        if (!ev.enable_on) begin
          draw_underline(1'b0);
          cur_shown = 1'b0;
          blink_cnt = '0;
        end
      end
      FUNC_CLEAR: begin
        cur_col   = '0;
        cur_row   = '0;
        cur_on    = 1'b0;
        cur_shown = 1'b0;
        blink_cnt = '0;
        add_draw(KIND_CLEAR, 7'd0, 6'd0, 8'd0, 24'd0, Palette[back_q]);
      end
      default: ;
    endcase
    if (event_draws.size() > 0) event_draws[event_draws.size() - 1].last = 1'b1;
    foreach (event_draws[i]) pending_draws.push_back(event_draws[i]);
  endfunction

  function automatic void compare_field(string field, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count_o++;
    end
  endfunction

  function automatic void check_draw(out_item_t got);
    out_item_t want;
    if (pending_draws.size() == 0) begin
      $error("draw command 0x%0h arrived with none expected", got);
      fail_count_o++;
      return;
    end
    want = pending_draws.pop_front();
    compare_field("kind", want.kind, got.kind);
    compare_field("cell_col", want.cell_col, got.cell_col);
    compare_field("cell_row", want.cell_row, got.cell_row);
    compare_field("glyph_code", want.glyph_code, got.glyph_code);
    compare_field("fore_rgb", want.fore_rgb, got.fore_rgb);
    compare_field("back_rgb", want.back_rgb, got.back_rgb);
    compare_field("last", want.last, got.last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q      = ResetColumns;
      rows_q         = ResetRows;
      fore_q         = ResetFore;
      back_q         = ResetBack;
      blink_period_q = ResetBlink;
      cur_col        = '0;
      cur_row        = '0;
      cur_on         = 1'b0;
      cur_shown      = 1'b0;
      blink_cnt      = '0;
      pending_draws.delete();
    end else begin
      // Draws leaving this cycle belong to events accepted earlier.
      if (out_valid_i && out_ready_i) check_draw(out_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TEXT_COLUMNS: columns_q      = cfg_data_i;
          REG_TEXT_ROWS:    rows_q         = cfg_data_i[6:0];
          REG_FORE_INDEX:   fore_q         = cfg_data_i[3:0];
          REG_BACK_INDEX:   back_q         = cfg_data_i[3:0];
          REG_BLINK_PERIOD: blink_period_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_event(in_data_i);
    end
    pending_o = pending_draws.size();
  end

endmodule

// ===== tb/sv/tb_text_console_cursor_engine.sv =====
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;
  import tcc_pkg::*;

  localparam logic [2:0] FuncReservedFirst = 3'd5;
  localparam logic [2:0] FuncReservedLast  = 3'd7;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_item_t  out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  int unsigned draw_failures;
  int unsigned draws_pending;
  bit          steady;
  bit          hold_request;
  int unsigned grid_cols_now;
  int unsigned grid_rows_now;

  text_console_cursor_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  text_console_cursor_checker draw_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (draw_failures),
    .pending_o    (draws_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2500000;
    $display("tb_text_console_cursor_engine NOT OK");
    $finish;
  end

  // Draw receiver. A hold request stops it for a long stretch so that the
  // command queue fills and input backs up.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_request = 1'b0;
      end
      out_ready_i <= steady || ($urandom_range(99) >= 27);
    end
  end

  function automatic in_item_t make_event(logic [2:0] func, logic [7:0] code,
                                          logic [6:0] col, logic [5:0] row, logic on);
    in_item_t ev;
    ev.func      = func;
    ev.byte_in   = code;
    ev.new_col   = col;
    ev.new_row   = row;
    ev.enable_on = on;
    return ev;
  endfunction

  function automatic in_item_t random_event();
    in_item_t    ev;
    int unsigned pick;
    int unsigned sub;
    ev = make_event(FUNC_CHAR, 8'($urandom_range(255)), 7'($urandom_range(127)),
                    6'($urandom_range(63)), 1'($urandom_range(1)));
    pick = $urandom_range(99);
    sub  = $urandom_range(9);
    if (pick < 45) begin
      if (sub == 0) ev.byte_in = CharNewline;
      else if (sub == 1) ev.byte_in = CharBackspace;
    end else if (pick < 72) begin
      ev.func = FUNC_TICK;
    end else if (pick < 84) begin
      ev.func = FUNC_SETPOS;
      // Mostly inside the grid; the rest lands anywhere the fields reach.
      if (sub < 8) begin
        ev.new_col = 7'($urandom_range(grid_cols_now - 1));
        ev.new_row = 6'($urandom_range(grid_rows_now - 1));
      end
    end else if (pick < 92) begin
      ev.func      = FUNC_ENABLE;
      ev.enable_on = (sub < 7);
    end else if (pick < 96) begin
      ev.func = FUNC_CLEAR;
    end else begin
      ev.func = 3'($urandom_range(FuncReservedLast, FuncReservedFirst));
    end
    return ev;
  endfunction

  task automatic send_event(in_item_t ev);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Waits until every expected draw has arrived and the engine has had time
  // to finish events that draw nothing.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (draws_pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_settings(logic [7:0] cols, logic [6:0] rows, logic [3:0] fore,
                               logic [3:0] back, logic [7:0] blink);
    write_reg(REG_TEXT_COLUMNS, cols);
    write_reg(REG_TEXT_ROWS, {1'b0, rows});
    write_reg(REG_FORE_INDEX, {4'd0, fore});
    write_reg(REG_BACK_INDEX, {4'd0, back});
    write_reg(REG_BLINK_PERIOD, blink);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    grid_cols_now = (cols == 0) ? 1 : (cols > 128) ? 128 : cols;
    grid_rows_now = (rows == 0) ? 1 : (rows > 64) ? 64 : rows;
  endtask

  task automatic run_random_phase(int unsigned target, bit hold_midway);
    int unsigned counted;
    in_item_t    ev;
    counted = 0;
    send_event(make_event(FUNC_ENABLE, 8'd0, 7'd0, 6'd0, 1'b1));
    while (counted < target) begin
      if (hold_midway && counted == target / 3) begin
        hold_request = 1'b1;
        hold_midway  = 1'b0;
      end
      ev = random_event();
      send_event(ev);
      if (ev.func <= FUNC_CLEAR) counted++;
    end
    settle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_TEXT_COLUMNS;
    cfg_data_i    = '0;
    steady        = 1'b0;
    hold_request  = 1'b0;
    grid_cols_now = ResetColumns;
    grid_rows_now = ResetRows;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: 80 by 25, cursor off.
    send_event(make_event(FUNC_CHAR, 8'h41, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FUNC_CHAR, 8'hFF, 7'd127, 6'd63, 1'b1));
    send_event(make_event(FUNC_CHAR, 8'h00, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FUNC_CHAR, CharNewline, 7'd0, 6'd0, 1'b0));
    // Backspace at the start of a row wraps to the end of the previous row.
    send_event(make_event(FUNC_CHAR, CharBackspace, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FUNC_CHAR, CharBackspace, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FUNC_SETPOS, 8'd0, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FUNC_CHAR, CharBackspace, 7'd0, 6'd0, 1'b0));
    // Positions outside the grid.
    send_event(make_event(FUNC_SETPOS, 8'hFF, 7'd127, 6'd63, 1'b1));
    send_event(make_event(FUNC_CHAR, 8'h7E, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FUNC_SETPOS, 8'd0, 7'd127, 6'd40, 1'b0));
    send_event(make_event(FUNC_CHAR, CharBackspace, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FUNC_CHAR, CharNewline, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FuncReservedFirst, 8'hFF, 7'd127, 6'd63, 1'b1));
    send_event(make_event(FuncReservedLast, 8'hFF, 7'd127, 6'd63, 1'b1));
    send_event(make_event(FUNC_ENABLE, 8'd0, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FUNC_CLEAR, 8'd0, 7'd0, 6'd0, 1'b0));
    settle();

    // Tiny grid with a zero blink period, so every tick toggles the cursor.
    load_settings(8'd3, 7'd2, 4'd0, 4'd15, 8'd0);
    send_event(make_event(FUNC_ENABLE, 8'd0, 7'd0, 6'd0, 1'b1));
    send_event(make_event(FUNC_TICK, 8'd0, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FUNC_CHAR, 8'h78, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FUNC_TICK, 8'd0, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FUNC_TICK, 8'd0, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FUNC_SETPOS, 8'd0, 7'd2, 6'd1, 1'b0));
    send_event(make_event(FUNC_CHAR, 8'h7A, 7'd0, 6'd0, 1'b0));
    send_event(make_event(FUNC_ENABLE, 8'd0, 7'd0, 6'd0, 1'b0));
    settle();

    load_settings(8'd0, 7'd0, 4'd15, 4'd0, 8'd3);
    run_random_phase(30, 1'b0);
    load_settings(8'd255, 7'd127, 4'd0, 4'd15, 8'd255);
    run_random_phase(30, 1'b0);
    steady = 1'b1;
    load_settings(8'd5, 7'd3, 4'($urandom_range(15)), 4'($urandom_range(15)), 8'd1);
    run_random_phase(30, 1'b0);
    steady = 1'b0;
    load_settings(8'd8, 7'd4, 4'($urandom_range(15)), 4'($urandom_range(15)), 8'd0);
    run_random_phase(30, 1'b1);
    load_settings(8'd128, 7'd64, 4'($urandom_range(15)), 4'($urandom_range(15)), 8'd2);
    run_random_phase(30, 1'b0);
    load_settings(8'd12, 7'd6, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  8'($urandom_range(6, 1)));
    run_random_phase(30, 1'b0);

    if (draw_failures == 0) begin
      $display("tb_text_console_cursor_engine OK");
    end else begin
      $display("tb_text_console_cursor_engine NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tcc_pkg.sv
design/tcc_front.sv
design/tcc_queue.sv
design/tcc_back.sv
design/text_console_cursor_engine.sv
tb/sv/text_console_cursor_checker.sv
tb/sv/tb_text_console_cursor_engine.sv
